>>> rtl/rclc_pkg.sv
// rclc_pkg: shared types, codes and reset values for the rc channel lamp controller
// used by every module under rtl
`timescale 1ns / 1ps

package rclc_pkg;

  localparam int WidthW   = 11;
  localparam int MagW     = 10;
  localparam int CountW   = 6;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 11;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_THROTTLE_CENTRE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SWITCH_CENTRE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEAD_ZONE        = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SWITCH_THRESHOLD = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HOLD_FRAMES      = 3'd4;

  localparam logic [10:0] RST_THROTTLE_CENTRE  = 11'd1520;
  localparam logic [10:0] RST_SWITCH_CENTRE    = 11'd1520;
  localparam logic [7:0]  RST_DEAD_ZONE        = 8'd20;
  localparam logic [8:0]  RST_SWITCH_THRESHOLD = 9'd200;
  localparam logic [5:0]  RST_HOLD_FRAMES      = 6'd25;

  localparam logic [CountW-1:0] COUNT_MAX = 6'd63;

  // three-way class codes, two's complement
  localparam logic [1:0] CLS_ZERO = 2'b00;
  localparam logic [1:0] CLS_POS  = 2'b01;
  localparam logic [1:0] CLS_NEG  = 2'b11;

  localparam logic [1:0] TURN_OFF    = 2'd0;
  localparam logic [1:0] TURN_LEFT   = 2'd1;
  localparam logic [1:0] TURN_RIGHT  = 2'd2;
  localparam logic [1:0] TURN_BEACON = 2'd3;

  localparam logic [1:0] STOP_OFF    = 2'd0;
  localparam logic [1:0] STOP_NORMAL = 2'd1;
  localparam logic [1:0] STOP_BRAKE  = 2'd2;

  localparam logic [1:0] HEAD_OFF = 2'd0;
  localparam logic [1:0] HEAD_LB  = 2'd1;
  localparam logic [1:0] HEAD_HB  = 2'd2;

  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_ONE   = 2'd1;
  localparam logic [1:0] PHASE_GAP   = 2'd2;
  localparam logic [1:0] PHASE_TWO   = 2'd3;

  typedef struct packed {
    logic [10:0] throttle_centre;
    logic [10:0] switch_centre;
    logic [7:0]  dead_zone;
    logic [8:0]  switch_threshold;
  } front_cfg_t;

  // classified frame passed from front to back
  typedef struct packed {
    logic [1:0]      drive_dir;
    logic [MagW-1:0] drive_mag;
    logic [1:0]      switch_position;
  } cls_t;

  typedef struct packed {
    logic [1:0]      police_lamp;
    logic [1:0]      turn_signal;
    logic [1:0]      head_lamp;
    logic            stop_delay_clear;
    logic [1:0]      stop_lamp;
    logic            reverse_lamp;
    logic [1:0]      switch_position;
    logic [MagW-1:0] drive_mag;
    logic [1:0]      drive_dir;
  } result_t;

endpackage

>>> rtl/rclc_front.sv
// rclc_front: accepts frames, classes throttle and switch widths into a registered stage
// depends on rclc_pkg
`timescale 1ns / 1ps

module rclc_front (
  input  logic                clk,
  input  logic                rst,
  input  rclc_pkg::front_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [10:0]         throttle_width,
  input  logic [10:0]         switch_width,
  output logic                out_valid,
  input  logic                out_ready,
  output rclc_pkg::cls_t      out_cls
);
  import rclc_pkg::*;

  logic        valid;
  cls_t        cls;
  cls_t        cls_next;
  logic [11:0] thr_hi;
  logic [11:0] thr_lo;
  logic [11:0] sw_hi;
  logic [11:0] sw_lo;
  logic [10:0] diff;

  always_comb begin
    thr_hi = {1'b0, cfg.throttle_centre} + {4'd0, cfg.dead_zone};
    thr_lo = {1'b0, throttle_width} + {4'd0, cfg.dead_zone};
    sw_hi  = {1'b0, cfg.switch_centre} + {3'd0, cfg.switch_threshold};
    sw_lo  = {1'b0, switch_width} + {3'd0, cfg.switch_threshold};

    if ({1'b0, throttle_width} > thr_hi) begin
      cls_next.drive_dir = CLS_POS;
    end else if (thr_lo < {1'b0, cfg.throttle_centre}) begin
      cls_next.drive_dir = CLS_NEG;
    end else begin
      cls_next.drive_dir = CLS_ZERO;
    end

    if (throttle_width >= cfg.throttle_centre) begin
      diff = throttle_width - cfg.throttle_centre;
    end else begin
      diff = cfg.throttle_centre - throttle_width;
    end
    cls_next.drive_mag = diff[10] ? {MagW{1'b1}} : diff[MagW-1:0];

    if ({1'b0, switch_width} > sw_hi) begin
      cls_next.switch_position = CLS_POS;
    end else if (sw_lo < {1'b0, cfg.switch_centre}) begin
      cls_next.switch_position = CLS_NEG;
    end else begin
      cls_next.switch_position = CLS_ZERO;
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_cls   = cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cls <= cls_next;
    end
  end

endmodule

>>> rtl/rclc_queue.sv
// rclc_queue: short fifo of classified frames between front and back
// depends on rclc_pkg
`timescale 1ns / 1ps

module rclc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           push_ready,
  input  rclc_pkg::cls_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output rclc_pkg::cls_t pop_data
);
  import rclc_pkg::*;

  cls_t                 mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = count != QueueCntW'(QueueDepth);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/rclc_back.sv
// rclc_back: lamp state update per classified frame and the result register
// depends on rclc_pkg
`timescale 1ns / 1ps

module rclc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [5:0]        hold_frames,
  input  logic              in_valid,
  output logic              in_pop,
  input  rclc_pkg::cls_t    in_cls,
  output logic              out_valid,
  input  logic              out_ready,
  output rclc_pkg::result_t out_result
);
  import rclc_pkg::*;

  logic              last_dir_nz, last_dir_nz_next;
  logic [1:0]        low_phase, low_phase_next;
  logic [1:0]        high_phase, high_phase_next;
  logic [CountW-1:0] low_count, low_count_next;
  logic [CountW-1:0] mid_count, mid_count_next;
  logic [CountW-1:0] high_count, high_count_next;
  logic [1:0]        head_mode, head_mode_next;
  logic [1:0]        stop_mode, stop_mode_next;
  logic [1:0]        turn_mode, turn_mode_next;
  logic [1:0]        police_mode, police_mode_next;
  logic              reverse_on, reverse_on_next;
  logic              delay_clear;
  logic              valid;
  result_t           result;
  result_t           result_next;
  logic [CountW-1:0] bump_src;
  logic [CountW-1:0] bump_inc;
  logic [CountW-1:0] bump_cnt;
  logic              long_hold;

  assign in_pop     = in_valid && (!valid || out_ready);
  assign out_valid  = valid;
  assign out_result = result;

  // one shared saturating hold counter step, the active class picks its source
  always_comb begin
    case (in_cls.switch_position)
      CLS_NEG: bump_src = low_count;
      CLS_POS: bump_src = high_count;
      default: bump_src = mid_count;
    endcase
    bump_inc  = (bump_src >= COUNT_MAX) ? COUNT_MAX : bump_src + 1'b1;
    long_hold = bump_inc > hold_frames;
    bump_cnt  = long_hold ? hold_frames + 1'b1 : bump_inc;
  end

  always_comb begin
    last_dir_nz_next = last_dir_nz;
    low_phase_next   = low_phase;
    high_phase_next  = high_phase;
    low_count_next   = low_count;
    mid_count_next   = mid_count;
    high_count_next  = high_count;
    head_mode_next   = head_mode;
    stop_mode_next   = stop_mode;
    turn_mode_next   = turn_mode;
    police_mode_next = police_mode;
    reverse_on_next  = reverse_on;
    delay_clear      = 1'b0;

    // throttle
    case (in_cls.drive_dir)
      CLS_POS, CLS_NEG: begin
        reverse_on_next = in_cls.drive_dir == CLS_NEG;
        stop_mode_next  = (head_mode != HEAD_OFF) ? STOP_NORMAL : STOP_OFF;
        delay_clear     = 1'b1;
      end
      default: begin
        reverse_on_next = 1'b0;
        if (head_mode != HEAD_OFF && stop_mode != STOP_BRAKE) begin
          stop_mode_next = STOP_NORMAL;
        end
        if (last_dir_nz) begin
          stop_mode_next = STOP_BRAKE;
        end
      end
    endcase
    last_dir_nz_next = in_cls.drive_dir != CLS_ZERO;

    // switch
    case (in_cls.switch_position)
      CLS_NEG: begin
        high_count_next = '0;
        mid_count_next  = '0;
        low_count_next  = bump_cnt;
        if (low_phase == PHASE_IDLE) begin
          low_phase_next = PHASE_ONE;
        end else if (low_phase == PHASE_GAP) begin
          low_phase_next = PHASE_TWO;
        end
        if (long_hold) begin
          turn_mode_next = TURN_LEFT;
          low_phase_next = PHASE_IDLE;
        end
      end
      CLS_POS: begin
        mid_count_next  = '0;
        low_count_next  = '0;
        high_count_next = bump_cnt;
        if (high_phase == PHASE_IDLE) begin
          high_phase_next = PHASE_ONE;
        end else if (high_phase == PHASE_GAP) begin
          high_phase_next = PHASE_TWO;
        end
        if (long_hold) begin
          turn_mode_next  = TURN_RIGHT;
          high_phase_next = PHASE_IDLE;
        end
      end
      default: begin
        high_count_next = '0;
        low_count_next  = '0;
        mid_count_next  = bump_cnt;
        if (turn_mode != TURN_BEACON) begin
          turn_mode_next = TURN_OFF;
        end
        if (long_hold) begin
          if (low_phase == PHASE_GAP) begin
            turn_mode_next = (turn_mode_next != TURN_BEACON) ? TURN_BEACON : TURN_OFF;
          end
          if (high_phase == PHASE_GAP) begin
            case (head_mode)
              HEAD_OFF: head_mode_next = HEAD_LB;
              HEAD_LB:  head_mode_next = HEAD_HB;
              default: begin
                head_mode_next = HEAD_OFF;
                stop_mode_next = STOP_OFF;
              end
            endcase
          end
          low_phase_next  = PHASE_IDLE;
          high_phase_next = PHASE_IDLE;
        end
        if (low_phase_next == PHASE_ONE) begin
          low_phase_next = PHASE_GAP;
        end else if (low_phase_next == PHASE_TWO) begin
          low_phase_next   = PHASE_IDLE;
          police_mode_next = police_mode + 1'b1;
        end
        if (high_phase_next == PHASE_ONE) begin
          high_phase_next = PHASE_GAP;
        end else if (high_phase_next == PHASE_TWO) begin
          high_phase_next = PHASE_IDLE;
        end
      end
    endcase

    result_next.drive_dir        = in_cls.drive_dir;
    result_next.drive_mag        = in_cls.drive_mag;
    result_next.switch_position  = in_cls.switch_position;
    result_next.reverse_lamp     = reverse_on_next;
    result_next.stop_lamp        = stop_mode_next;
    result_next.stop_delay_clear = delay_clear;
    result_next.head_lamp        = head_mode_next;
    result_next.turn_signal      = turn_mode_next;
    result_next.police_lamp      = police_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      last_dir_nz <= 1'b0;
      low_phase   <= PHASE_IDLE;
      high_phase  <= PHASE_IDLE;
      low_count   <= '0;
      mid_count   <= '0;
      high_count  <= '0;
      head_mode   <= HEAD_OFF;
      stop_mode   <= STOP_OFF;
      turn_mode   <= TURN_OFF;
      police_mode <= '0;
      reverse_on  <= 1'b0;
    end else begin
      if (in_pop) begin
        valid       <= 1'b1;
        last_dir_nz <= last_dir_nz_next;
        low_phase   <= low_phase_next;
        high_phase  <= high_phase_next;
        low_count   <= low_count_next;
        mid_count   <= mid_count_next;
        high_count  <= high_count_next;
        head_mode   <= head_mode_next;
        stop_mode   <= stop_mode_next;
        turn_mode   <= turn_mode_next;
        police_mode <= police_mode_next;
        reverse_on  <= reverse_on_next;
      end else if (out_ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      result <= result_next;
    end
  end

endmodule

>>> rtl/rc_channel_lamp_controller.sv
// rc_channel_lamp_controller: top level, configuration registers, front, queue and back
// depends on rclc_pkg, rclc_front, rclc_queue, rclc_back
// path: an accepted input beat passes the front stage register, a queue entry and the result register
// throughput: one frame per cycle when neither side stalls; front stage, two-entry queue and result
// register each hold a beat so either side can stall on its own
// reset: synchronous rst clears all lamp state and restores register defaults
`timescale 1ns / 1ps

module rc_channel_lamp_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // throttle_width[10:0], switch_width[21:11], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  // drive_dir[1:0], drive_mag[11:2], switch_position[13:12],
  // reverse_lamp[14], stop_lamp[16:15], stop_delay_clear[17], head_lamp[19:18],
  // turn_signal[21:20], police_lamp[23:22]
  output logic [23:0] m_tdata,
  input  logic        cfg_wr_en,
  input  logic [rclc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rclc_pkg::CfgDataW-1:0] cfg_wdata
);
  import rclc_pkg::*;

  front_cfg_t cfg;
  logic [5:0] hold_frames;
  logic       f_valid;
  logic       q_ready;
  cls_t       f_cls;
  logic       q_valid;
  logic       q_pop;
  cls_t       q_cls;
  result_t    result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.throttle_centre  <= RST_THROTTLE_CENTRE;
      cfg.switch_centre    <= RST_SWITCH_CENTRE;
      cfg.dead_zone        <= RST_DEAD_ZONE;
      cfg.switch_threshold <= RST_SWITCH_THRESHOLD;
      hold_frames          <= RST_HOLD_FRAMES;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_THROTTLE_CENTRE:  cfg.throttle_centre  <= cfg_wdata[10:0];
        REG_SWITCH_CENTRE:    cfg.switch_centre    <= cfg_wdata[10:0];
        REG_DEAD_ZONE:        cfg.dead_zone        <= cfg_wdata[7:0];
        REG_SWITCH_THRESHOLD: cfg.switch_threshold <= cfg_wdata[8:0];
        REG_HOLD_FRAMES:      hold_frames          <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  rclc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .throttle_width (s_tdata[10:0]),
    .switch_width   (s_tdata[21:11]),
    .out_valid      (f_valid),
    .out_ready      (q_ready),
    .out_cls        (f_cls)
  );

  rclc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .push_ready (q_ready),
    .push_data  (f_cls),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_cls)
  );

  rclc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .hold_frames (hold_frames),
    .in_valid    (q_valid),
    .in_pop      (q_pop),
    .in_cls      (q_cls),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (result)
  );

  assign m_tdata = result;

endmodule

>>> verif/tb.sv
// tb: self-checking bench for rc_channel_lamp_controller, frames in and lamp states out
// a lamp state predictor checks every output beat; depends on rclc_pkg and the rtl
`timescale 1ns / 1ps

module tb;
  import rclc_pkg::*;

  localparam int QUIET_START    = 900;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_OFF       = 50;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 40;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd6;

  typedef struct packed {
    logic [10:0] sw;
    logic [10:0] thr;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // register copy
  logic [10:0] cfg_throttle_centre  = RST_THROTTLE_CENTRE;
  logic [10:0] cfg_switch_centre    = RST_SWITCH_CENTRE;
  logic [7:0]  cfg_dead_zone        = RST_DEAD_ZONE;
  logic [8:0]  cfg_switch_threshold = RST_SWITCH_THRESHOLD;
  logic [5:0]  cfg_hold_frames      = RST_HOLD_FRAMES;

  // lamp state copy
  logic        st_last_moving = 1'b0;
  logic [1:0]  st_low_phase   = PHASE_IDLE;
  logic [1:0]  st_high_phase  = PHASE_IDLE;
  logic [5:0]  st_low_count   = '0;
  logic [5:0]  st_mid_count   = '0;
  logic [5:0]  st_high_count  = '0;
  logic [1:0]  st_head        = HEAD_OFF;
  logic [1:0]  st_stop        = STOP_OFF;
  logic [1:0]  st_turn        = TURN_OFF;
  logic [1:0]  st_police      = 2'd0;
  logic        st_reverse     = 1'b0;

  frame_t  frame_backlog[$];
  result_t lamp_expect[$];
  frame_t  held_frame;
  bit      frame_held = 1'b0;
  int      frames_in = 0;
  int      frames_out = 0;
  int      errors = 0;
  int      src_gap = 0;
  int      sink_gap = 0;
  int      sink_hold = 0;
  int      stall_cycles = 0;

  rc_channel_lamp_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [5:0] bump_hold(logic [5:0] cnt, output bit long_hold);
    logic [5:0] nxt;
    nxt = (cnt >= COUNT_MAX) ? COUNT_MAX : cnt + 6'd1;
    long_hold = nxt > cfg_hold_frames;
    if (long_hold) nxt = cfg_hold_frames + 6'd1;
    return nxt;
  endfunction

  task automatic advance_lamps(frame_t f);
    int thr, sw, tc, sc, dz, th, mag;
    logic [1:0] dir, pos;
    logic clear;
    bit lh;
    result_t r;
    thr = f.thr;
    sw = f.sw;
    tc = cfg_throttle_centre;
    sc = cfg_switch_centre;
    dz = cfg_dead_zone;
    th = cfg_switch_threshold;
    clear = 1'b0;

    if (thr > tc + dz) begin
      dir = CLS_POS;
      st_reverse = 1'b0;
      st_stop = (st_head != HEAD_OFF) ? STOP_NORMAL : STOP_OFF;
      clear = 1'b1;
    end else if (thr < tc - dz) begin
      dir = CLS_NEG;
      st_reverse = 1'b1;
      st_stop = (st_head != HEAD_OFF) ? STOP_NORMAL : STOP_OFF;
      clear = 1'b1;
    end else begin
      dir = CLS_ZERO;
      st_reverse = 1'b0;
      if (st_head != HEAD_OFF && st_stop != STOP_BRAKE) st_stop = STOP_NORMAL;
      if (st_last_moving) st_stop = STOP_BRAKE;
    end
    st_last_moving = (dir != CLS_ZERO);
    mag = (thr > tc) ? thr - tc : tc - thr;
    if (mag > 1023) mag = 1023;

    if (sw > sc + th) pos = CLS_POS;
    else if (sw < sc - th) pos = CLS_NEG;
    else pos = CLS_ZERO;

    if (pos == CLS_NEG) begin
      st_high_count = '0;
      st_mid_count = '0;
      st_low_count = bump_hold(st_low_count, lh);
      if (st_low_phase == PHASE_IDLE) st_low_phase = PHASE_ONE;
      if (st_low_phase == PHASE_GAP) st_low_phase = PHASE_TWO;
      if (lh) begin
        st_turn = TURN_LEFT;
        st_low_phase = PHASE_IDLE;
      end
    end else if (pos == CLS_ZERO) begin
      st_high_count = '0;
      st_low_count = '0;
      st_mid_count = bump_hold(st_mid_count, lh);
      if (st_turn != TURN_BEACON) st_turn = TURN_OFF;
      if (lh) begin
        if (st_low_phase == PHASE_GAP)
          st_turn = (st_turn != TURN_BEACON) ? TURN_BEACON : TURN_OFF;
        if (st_high_phase == PHASE_GAP) begin
          if (st_head == HEAD_OFF) begin
            st_head = HEAD_LB;
          end else if (st_head == HEAD_LB) begin
            st_head = HEAD_HB;
          end else begin
            st_head = HEAD_OFF;
            st_stop = STOP_OFF;
          end
        end
        st_low_phase = PHASE_IDLE;
        st_high_phase = PHASE_IDLE;
      end
      if (st_low_phase == PHASE_ONE) st_low_phase = PHASE_GAP;
      if (st_high_phase == PHASE_ONE) st_high_phase = PHASE_GAP;
      if (st_low_phase == PHASE_TWO) begin
        st_low_phase = PHASE_IDLE;
        st_police = st_police + 2'd1;
      end
      if (st_high_phase == PHASE_TWO) st_high_phase = PHASE_IDLE;
    end else begin
      st_mid_count = '0;
      st_low_count = '0;
      st_high_count = bump_hold(st_high_count, lh);
      if (st_high_phase == PHASE_IDLE) st_high_phase = PHASE_ONE;
      if (st_high_phase == PHASE_GAP) st_high_phase = PHASE_TWO;
      if (lh) begin
        st_turn = TURN_RIGHT;
        st_high_phase = PHASE_IDLE;
      end
    end

    r.drive_dir        = dir;
    r.drive_mag        = mag[9:0];
    r.switch_position  = pos;
    r.reverse_lamp     = st_reverse;
    r.stop_lamp        = st_stop;
    r.stop_delay_clear = clear;
    r.head_lamp        = st_head;
    r.turn_signal      = st_turn;
    r.police_lamp      = st_police;
    lamp_expect.push_back(r);
  endtask

  task automatic report_error(string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("mismatch: %s", msg);
  endtask

  task automatic compare_field(string name, logic [9:0] got, logic [9:0] want);
    if (got !== want)
      report_error($sformatf("beat %0d %s got %0d want %0d", frames_out, name, got, want));
  endtask

  task automatic check_lamps(logic [23:0] beat);
    result_t got, want;
    got = result_t'(beat);
    if (lamp_expect.size() == 0) begin
      report_error($sformatf("output beat %h with nothing expected", beat));
      return;
    end
    want = lamp_expect.pop_front();
    compare_field("drive_dir", 10'(got.drive_dir), 10'(want.drive_dir));
    compare_field("drive_mag", got.drive_mag, want.drive_mag);
    compare_field("switch_position", 10'(got.switch_position), 10'(want.switch_position));
    compare_field("reverse_lamp", 10'(got.reverse_lamp), 10'(want.reverse_lamp));
    compare_field("stop_lamp", 10'(got.stop_lamp), 10'(want.stop_lamp));
    compare_field("stop_delay_clear", 10'(got.stop_delay_clear),
                  10'(want.stop_delay_clear));
    compare_field("head_lamp", 10'(got.head_lamp), 10'(want.head_lamp));
    compare_field("turn_signal", 10'(got.turn_signal), 10'(want.turn_signal));
    compare_field("police_lamp", 10'(got.police_lamp), 10'(want.police_lamp));
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
      frame_held = 1'b0;
    end else begin
      if (frame_held && s_tready) begin
        advance_lamps(held_frame);
        frames_in++;
        frame_held = 1'b0;
      end
      if (!frame_held) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (frames_in < QUIET_START && frames_in[4] && $urandom_range(3, 0) == 0) begin
          src_gap = $urandom_range(2, 0);
          s_tvalid <= 1'b0;
        end else if (frame_backlog.size() > 0) begin
          held_frame = frame_backlog.pop_front();
          frame_held = 1'b1;
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, held_frame.sw, held_frame.thr};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
      sink_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_lamps(m_tdata);
        frames_out++;
        if (frames_out == 300 || frames_out == 700) sink_hold = HOLD_OFF;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (frames_out < QUIET_START && frames_out[5] && $urandom_range(4, 0) == 0) begin
        sink_gap = $urandom_range(2, 0);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_THROTTLE_CENTRE:  cfg_throttle_centre = data;
      REG_SWITCH_CENTRE:    cfg_switch_centre = data;
      REG_DEAD_ZONE:        cfg_dead_zone = data[7:0];
      REG_SWITCH_THRESHOLD: cfg_switch_threshold = data[8:0];
      REG_HOLD_FRAMES:      cfg_hold_frames = data[5:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(int tc, int sc, int dz, int th, int hf);
    write_reg(REG_THROTTLE_CENTRE, CfgDataW'(tc));
    write_reg(REG_SWITCH_CENTRE, CfgDataW'(sc));
    write_reg(REG_DEAD_ZONE, CfgDataW'(dz));
    write_reg(REG_SWITCH_THRESHOLD, CfgDataW'(th));
    write_reg(REG_HOLD_FRAMES, CfgDataW'(hf));
  endtask

  task automatic wait_idle();
    while (frame_backlog.size() > 0 || frame_held || lamp_expect.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic frame_t make_frame(int thr, int sw);
    frame_t f;
    f.thr = thr[10:0];
    f.sw = sw[10:0];
    return f;
  endfunction

  function automatic int pick_throttle();
    int tc, dz, lo, hi, pick;
    tc = cfg_throttle_centre;
    dz = cfg_dead_zone;
    pick = $urandom_range(9, 0);
    if (pick < 4) begin
      lo = (tc - dz < 0) ? 0 : tc - dz;
      hi = (tc + dz > 2047) ? 2047 : tc + dz;
      return $urandom_range(hi, lo);
    end
    if (pick == 4) return $urandom_range(2047, 0);
    return $urandom_range(2000, 1000);
  endfunction

  function automatic int pick_switch(logic [1:0] cls);
    int sc, th, lo, hi;
    sc = cfg_switch_centre;
    th = cfg_switch_threshold;
    if (cls == CLS_POS) begin
      lo = (sc + th + 1 < 1000) ? 1000 : sc + th + 1;
      hi = 2000;
      if (lo > hi) hi = 2047;
    end else if (cls == CLS_NEG) begin
      lo = 1000;
      hi = (sc - th - 1 > 2000) ? 2000 : sc - th - 1;
      if (hi < lo) lo = 0;
    end else begin
      lo = sc - th;
      hi = sc + th;
    end
    if (lo < 0) lo = 0;
    if (hi > 2047) hi = 2047;
    // class out of reach under this setting
    if (lo > hi) begin
      lo = sc;
      hi = sc;
    end
    return $urandom_range(hi, lo);
  endfunction

  task automatic push_switch(logic [1:0] cls, int count);
    repeat (count) frame_backlog.push_back(make_frame(pick_throttle(), pick_switch(cls)));
  endtask

  // click, double click, long hold or noise, each with random throttle
  task automatic add_gesture();
    int hf, click_max, rest, kind;
    logic [1:0] cls;
    hf = cfg_hold_frames;
    click_max = (hf < 1) ? 1 : ((hf > 3) ? 3 : hf);
    rest = hf + 1 + $urandom_range(2, 0);
    kind = $urandom_range(9, 0);
    cls = (kind[0]) ? CLS_POS : CLS_NEG;
    case (kind)
      0, 1, 2, 3: begin
        push_switch(cls, $urandom_range(click_max, 1));
        push_switch(CLS_ZERO, rest);
      end
      4, 5: begin
        push_switch(cls, $urandom_range(click_max, 1));
        push_switch(CLS_ZERO, $urandom_range(click_max, 1));
        push_switch(cls, $urandom_range(click_max, 1));
        push_switch(CLS_ZERO, rest);
      end
      6, 7: push_switch(cls, hf + 1 + $urandom_range(3, 0));
      default: begin
        repeat ($urandom_range(6, 1))
          frame_backlog.push_back(make_frame(pick_throttle(), $urandom_range(2047, 0)));
      end
    endcase
  endtask

  task automatic fill_phase(int budget);
    while (frame_backlog.size() < budget) add_gesture();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // band edges around the default centres, bit patterns and field extremes
    frame_backlog.push_back(make_frame(1520, 1520));
    frame_backlog.push_back(make_frame(2000, 1520));
    frame_backlog.push_back(make_frame(1520, 1520));
    frame_backlog.push_back(make_frame(1000, 1520));
    frame_backlog.push_back(make_frame(1540, 1520));
    frame_backlog.push_back(make_frame(1541, 1520));
    frame_backlog.push_back(make_frame(1500, 1520));
    frame_backlog.push_back(make_frame(1499, 1520));
    frame_backlog.push_back(make_frame(1520, 1720));
    frame_backlog.push_back(make_frame(1520, 1721));
    frame_backlog.push_back(make_frame(1520, 1320));
    frame_backlog.push_back(make_frame(1520, 1319));
    frame_backlog.push_back(make_frame(1520, 1520));
    frame_backlog.push_back(make_frame(2047, 2047));
    frame_backlog.push_back(make_frame(0, 0));
    frame_backlog.push_back(make_frame(1024, 1023));
    frame_backlog.push_back(make_frame(1023, 1024));
    frame_backlog.push_back(make_frame(1520, 2000));
    frame_backlog.push_back(make_frame(1520, 1000));
    frame_backlog.push_back(make_frame(1365, 682));
    frame_backlog.push_back(make_frame(682, 1365));
    wait_idle();

    fill_phase(250);
    wait_idle();

    set_config(1500, 1500, 0, 0, 3);
    fill_phase(250);
    wait_idle();

    set_config(2000, 1000, 255, 500, 1);
    fill_phase(150);
    wait_idle();

    // hold_frames at its top: long holds never fire
    set_config(1000, 2000, 0, 0, 63);
    fill_phase(100);
    wait_idle();

    // centres below their bands, masked writes, hold of zero, unused index
    set_config(10, 5, 11'h7FF, 11'h7FF, 11'd64);
    write_reg(REG_UNUSED, 11'h7FF);
    frame_backlog.push_back(make_frame(2047, 2047));
    frame_backlog.push_back(make_frame(0, 0));
    frame_backlog.push_back(make_frame(2047, 0));
    frame_backlog.push_back(make_frame(0, 2047));
    fill_phase(100);
    wait_idle();

    set_config(1520, 1520, 20, 200, 4);
    fill_phase(200);
    wait_idle();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rclc_pkg.sv
rtl/rclc_front.sv
rtl/rclc_queue.sv
rtl/rclc_back.sv
rtl/rc_channel_lamp_controller.sv
verif/tb.sv
